@@ rtl/mfhp_pkg.sv @@
// ----------------------------------------------------------------------------
// MQTT fixed header parser package
// Shared constants, result type and length helpers.
// ----------------------------------------------------------------------------
package mfhp_pkg;

  // Longest remaining-length varint, in bytes (1 to 4).
  localparam int unsigned MAX_LEN_BYTES = 4;
  // Seven-bit groups that a 28-bit remaining length can hold.
  localparam int unsigned LEN_GROUPS = 4;
  // Depth of the result queue.
  localparam int unsigned QDEPTH = 3;

  // Control packet types.
  localparam logic [3:0] T_RESERVED0   = 4'd0;
  localparam logic [3:0] T_CONNECT     = 4'd1;
  localparam logic [3:0] T_PUBLISH     = 4'd3;
  localparam logic [3:0] T_PUBREL      = 4'd6;
  localparam logic [3:0] T_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] T_UNSUBSCRIBE = 4'd10;
  localparam logic [3:0] T_PINGREQ     = 4'd12;
  localparam logic [3:0] T_PINGRESP    = 4'd13;
  localparam logic [3:0] T_DISCONNECT  = 4'd14;
  localparam logic [3:0] T_RESERVED15  = 4'd15;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RESERVED = 3'd1;
  localparam logic [2:0] ST_TYPE     = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_VARINT   = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [27:0] decoded_len;
    logic [27:0] pay_len;
    logic [16:0] var_len;
    logic [2:0]  fixed_len;
    logic [1:0]  qos_level;
    logic [3:0]  packet_type;
  } res_t;

  // Fixed header length: one type byte plus the minimal varint length.
  function automatic logic [2:0] fixed_len_of(input logic [27:0] v);
    logic [2:0] n;
    n = 3'd1;
    for (int i = 1; i < LEN_GROUPS; i++) begin
      if ((v >= (28'd1 << (7 * i))) && (n < 3'(MAX_LEN_BYTES))) begin
        n = n + 3'd1;
      end
    end
    return n + 3'd1;
  endfunction

endpackage

@@ rtl/mfhp_parse_core.sv @@
// ----------------------------------------------------------------------------
// MQTT fixed header parser core
// Header state and the per-byte decode that yields at most one result.
// ----------------------------------------------------------------------------
module mfhp_parse_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  logic [7:0]    rx_byte,
  input  logic          pkt_start,
  output logic          res_valid,
  output mfhp_pkg::res_t res
);
  import mfhp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_LEN      = 4'b0010,
    PH_TOPIC_HI = 4'b0100,
    PH_TOPIC_LO = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [27:0] len_acc_r, len_acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  topic_hi_r, topic_hi_nxt;

  logic [4:0]  shamt;
  logic [27:0] sum_acc;
  logic [2:0]  cnt_inc;
  logic [1:0]  qos;
  logic [16:0] id_len;
  logic [16:0] topic_var;
  logic [16:0] type_var;
  logic [3:0]  type_need;
  logic [2:0]  type_st;
  logic [27:0] fin_r;
  logic [16:0] fin_var;
  logic [2:0]  fin_st0;
  logic [2:0]  fin_fix;
  logic        fin_over;
  logic [27:0] fin_pay;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    shamt = 5'd0;
      2'd1:    shamt = 5'd7;
      2'd2:    shamt = 5'd14;
      default: shamt = 5'd21;
    endcase
    sum_acc   = len_acc_r + (28'(rx_byte[6:0]) << shamt);
    cnt_inc   = cnt_r + 3'd1;
    qos       = (type_r == T_PUBLISH) ? flags_r[2:1] : 2'd0;
    id_len    = ((qos == 2'd1) || (qos == 2'd2)) ? 17'd2 : 17'd0;
    topic_var = 17'({topic_hi_r, rx_byte}) + 17'd2 + id_len;

    // Variable header length and reserved flag nibble for non-PUBLISH types.
    type_var  = 17'd2;
    type_need = 4'h0;
    type_st   = ST_OK;
    case (type_r)
      T_CONNECT: begin
        type_var = 17'd10;
      end
      T_PUBREL, T_SUBSCRIBE, T_UNSUBSCRIBE: begin
        type_need = 4'h2;
      end
      T_PINGREQ, T_PINGRESP, T_DISCONNECT: begin
        type_var = 17'd0;
      end
      T_RESERVED0, T_RESERVED15: begin
        type_var = 17'd0;
        type_st  = ST_TYPE;
      end
      default: begin
      end
    endcase
    if ((type_st == ST_OK) && (flags_r != type_need)) begin
      type_st = ST_RESERVED;
    end

    // Shared length check for the end of a header.
    if (phase_r == PH_TOPIC_LO) begin
      fin_r   = len_acc_r;
      fin_var = topic_var;
      fin_st0 = ST_OK;
    end else begin
      fin_r   = sum_acc;
      fin_var = type_var;
      fin_st0 = type_st;
    end
    fin_fix  = fixed_len_of(fin_r);
    fin_over = {12'd0, fin_var} >= ({1'b0, fin_r} + 29'(fin_fix));
    if (!fin_over && ({11'd0, fin_var} < fin_r)) begin
      fin_pay = fin_r - 28'(fin_var);
    end else begin
      fin_pay = 28'd0;
    end

    phase_nxt    = phase_r;
    type_nxt     = type_r;
    flags_nxt    = flags_r;
    len_acc_nxt  = len_acc_r;
    cnt_nxt      = cnt_r;
    topic_hi_nxt = topic_hi_r;
    res_valid    = 1'b0;
    res.packet_type = type_r;
    res.qos_level   = qos;
    res.fixed_len   = fin_fix;
    res.var_len     = fin_var;
    res.pay_len     = fin_pay;
    res.decoded_len = fin_r;
    res.status      = fin_over ? ST_LENGTH : fin_st0;

    if (pkt_start) begin
      type_nxt     = rx_byte[7:4];
      flags_nxt    = rx_byte[3:0];
      len_acc_nxt  = 28'd0;
      cnt_nxt      = 3'd0;
      topic_hi_nxt = 8'd0;
      phase_nxt    = PH_LEN;
    end else begin
      case (phase_r)
        PH_LEN: begin
          len_acc_nxt = sum_acc;
          cnt_nxt     = cnt_inc;
          if (rx_byte[7]) begin
            if (cnt_inc >= 3'(MAX_LEN_BYTES)) begin
              // Continuation on the last allowed length byte: malformed.
              len_acc_nxt     = 28'd0;
              phase_nxt       = PH_IDLE;
              res_valid       = 1'b1;
              res.fixed_len   = 3'd2;
              res.var_len     = 17'd0;
              res.pay_len     = 28'd0;
              res.decoded_len = 28'd0;
              res.status      = ST_VARINT;
            end
          end else if (type_r == T_PUBLISH) begin
            if (sum_acc < 28'd2) begin
              // No room for the topic length bytes.
              phase_nxt   = PH_IDLE;
              res_valid   = 1'b1;
              res.var_len = 17'd2 + id_len;
              res.pay_len = 28'd0;
              res.status  = ST_LENGTH;
            end else begin
              phase_nxt = PH_TOPIC_HI;
            end
          end else begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
          end
        end
        PH_TOPIC_HI: begin
          topic_hi_nxt = rx_byte;
          phase_nxt    = PH_TOPIC_LO;
        end
        PH_TOPIC_LO: begin
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    res_valid = res_valid && item_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      type_r     <= 4'd0;
      flags_r    <= 4'd0;
      len_acc_r  <= 28'd0;
      cnt_r      <= 3'd0;
      topic_hi_r <= 8'd0;
    end else if (item_valid) begin
      phase_r    <= phase_nxt;
      type_r     <= type_nxt;
      flags_r    <= flags_nxt;
      len_acc_r  <= len_acc_nxt;
      cnt_r      <= cnt_nxt;
      topic_hi_r <= topic_hi_nxt;
    end
  end

endmodule

@@ rtl/mfhp_result_queue.sv @@
// ----------------------------------------------------------------------------
// MQTT fixed header parser result queue
// Small register queue that holds results until the receiver takes them.
// ----------------------------------------------------------------------------
module mfhp_result_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mfhp_pkg::res_t push_data,
  input  logic           pop,
  output logic           valid,
  output mfhp_pkg::res_t data,
  output logic [1:0]     count
);
  import mfhp_pkg::*;

  res_t       entry_r [QDEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign valid  = (cnt_r != 2'd0);
  assign data   = entry_r[rd_ptr_r];
  assign count  = cnt_r;
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == 2'(QDEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == 2'(QDEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    cnt_nxt = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/mqtt_fixed_header_parser_top.sv @@
// ----------------------------------------------------------------------------
// MQTT fixed header parser, top level
// Decodes the fixed header of received MQTT packets, one byte per cycle while in_tready is high.
// ----------------------------------------------------------------------------
// The input stream carries one received byte per request in in_tdata, with
// in_tuser set on the first byte of each packet. For every packet whose
// header completes, one result request appears on the output stream: packet
// type, QoS, fixed header length, variable header length, payload length,
// decoded remaining length and a status code. Bytes after the header, and
// bytes that arrive while no packet is open, produce nothing.
//
// A byte is captured in an input register and decoded in the following
// cycle; the result is then written into the result queue, whose count
// drives out_tvalid. The block takes one byte every cycle while in_tready
// is high: the decode is a single pass of a shift, an add and a compare.
//
// Results go into a three-entry queue. in_tready drops while the queued
// results plus a byte still in the input register reach three, since that
// byte may complete a header. A stalled receiver therefore holds back the
// input once the queue is about to fill, and no result is ever lost.
//
// Reset (rst_n low, synchronous) empties the queue and the input register
// and returns the parser to waiting for a start byte.
module mqtt_fixed_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] pkt_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] packet_type, [5:4] qos_level, [8:6] fixed_len, [25:9] var_len,
  // [53:26] pay_len, [81:54] decoded_len, [84:82] status, [87:85] zero
  output logic [87:0] out_tdata
);
  import mfhp_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       in_acc;
  logic       res_valid;
  res_t       res;
  res_t       q_data;
  logic [1:0] q_count;

  // Room check: every result the queue might have to take must fit.
  assign in_tready = ({1'b0, q_count} + {2'b00, s1_valid_r}) <= 3'(QDEPTH - 1);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser[0];
    end
  end

  mfhp_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .rx_byte    (s1_byte_r),
    .pkt_start  (s1_start_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  mfhp_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_tready),
    .valid     (out_tvalid),
    .data      (q_data),
    .count     (q_count)
  );

  assign out_tdata = {3'b000, q_data.status, q_data.decoded_len, q_data.pay_len,
                      q_data.var_len, q_data.fixed_len, q_data.qos_level,
                      q_data.packet_type};

endmodule

@@ rtl/mfhp_checker.sv @@
// ----------------------------------------------------------------------------
// MQTT fixed header parser port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module mfhp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);
  import mfhp_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A malformed varint reports fixed defaults.
  a_varint: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[84:82] == ST_VARINT) |->
      (out_tdata[81:54] == 28'd0) && (out_tdata[8:6] == 3'd2) &&
      (out_tdata[25:9] == 17'd0) && (out_tdata[53:26] == 28'd0))
    else $error("malformed varint result has stray lengths");

  // A nonzero payload is the remaining length less the variable header.
  a_pay_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[53:26] != 28'd0) |->
      ({1'b0, out_tdata[53:26]} + {12'd0, out_tdata[25:9]}) ==
      {1'b0, out_tdata[81:54]})
    else $error("payload length does not match remaining length");

  // A new result traces back to an accepted byte, through the input register and the queue.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a preceding byte");

  // With nothing queued the input is never held off.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result queue");

endmodule

bind mqtt_fixed_header_parser_top mfhp_checker u_mfhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
